// ===== rtl/stable_priority_queue_macros.svh =====
// Assertion macros for the stable priority queue checker.
// Used by spq_checker.sv only; no other dependencies.
`ifndef STABLE_PRIORITY_QUEUE_MACROS_SVH
`define STABLE_PRIORITY_QUEUE_MACROS_SVH

// Property checked while out of reset.
`define SPQ_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property that must also hold across reset.
`define SPQ_CHECK_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/spq_pkg.sv =====
// Shared types and codes for the stable priority queue.
// No dependencies; used by spq_cell, stable_priority_queue and spq_checker.
package spq_pkg;

  typedef enum logic [2:0] {
    KIND_INSERT       = 3'd0,
    KIND_POP_FRONT    = 3'd1,
    KIND_REMOVE_BACK  = 3'd2,
    KIND_REMOVE_VALUE = 3'd3,
    KIND_SEARCH       = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  localparam int VALUE_W = 32;

  // Broadcast to every cell.
  typedef struct packed {
    logic  apply;   // word accepted and the list changes
    kind_t kind;
  } cmd_t;

  // Per-cell flags seen by the top level and the neighbor.
  typedef struct packed {
    logic ge;          // valid and priority >= incoming priority
    logic match_incl;  // a match here or nearer the front
    logic hit;         // entry that a removal or search acts on
    logic ins;         // insert point
  } cell_flags_t;

endpackage

// ===== rtl/spq_cell.sv =====
// One slot of the sorted list: holds one entry, shifts to/from neighbors.
// Depends on spq_pkg.
module spq_cell #(
  parameter int PRIORITY_BITS = 8
) (
  input  logic                               clk,
  input  spq_pkg::cmd_t                      cmd,
  input  logic signed [spq_pkg::VALUE_W-1:0] new_value,
  input  logic        [PRIORITY_BITS-1:0]    new_prio,
  input  logic                               valid_here,
  input  logic                               valid_right,
  input  logic                               left_ge,
  input  logic                               match_before,
  input  logic signed [spq_pkg::VALUE_W-1:0] left_value,
  input  logic        [PRIORITY_BITS-1:0]    left_prio,
  input  logic signed [spq_pkg::VALUE_W-1:0] right_value,
  input  logic        [PRIORITY_BITS-1:0]    right_prio,
  output spq_pkg::cell_flags_t               flags,
  output logic signed [spq_pkg::VALUE_W-1:0] entry_value,
  output logic        [PRIORITY_BITS-1:0]    entry_prio
);
  import spq_pkg::*;

  logic match;

  always_comb begin
    match            = valid_here && (entry_value == new_value);
    flags.ge         = valid_here && (entry_prio >= new_prio);
    flags.match_incl = match_before || match;
    flags.ins        = left_ge && !flags.ge;
    if (cmd.kind == KIND_REMOVE_BACK) begin
      flags.hit = valid_here && !valid_right;
    end else begin
      flags.hit = match && !match_before;
    end
  end

  // Insert: the insert point takes the new entry; slots behind it take the left neighbor.
  // Removals: the removed slot and everything behind it take the right neighbor.
  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      unique case (cmd.kind)
        KIND_INSERT: begin
          if (flags.ins) begin
            entry_value <= new_value;
            entry_prio  <= new_prio;
          end else if (!flags.ge) begin
            entry_value <= left_value;
            entry_prio  <= left_prio;
          end
        end
        KIND_POP_FRONT: begin
          entry_value <= right_value;
          entry_prio  <= right_prio;
        end
        KIND_REMOVE_BACK: begin
          if (!valid_right) begin
            entry_value <= right_value;
            entry_prio  <= right_prio;
          end
        end
        KIND_REMOVE_VALUE: begin
          if (flags.match_incl) begin
            entry_value <= right_value;
            entry_prio  <= right_prio;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== rtl/stable_priority_queue.sv =====
// Stable priority queue: a row of spq_cell slots kept sorted by priority.
// Depends on spq_pkg and spq_cell.
//
//   channel | signals                                   | dir | moves
//   --------+-------------------------------------------+-----+---------------
//   in      | in_valid, in_stall, kind, item_value,     | in  | one op word
//           | item_priority                             |     |
//   out     | out_valid, out_stall, status, out_value,  | out | one result word
//           | out_priority, position, occupancy         |     |
//
// On acceptance of an op word the cells compare against the broadcast
// priority/value, shift in the same edge, and the result lands in the output
// register the cycle after acceptance. One word per cycle is sustained while
// the output is taken; the output register is the only buffering, so a
// stalled result holds in_stall high. Reset (synchronous) empties the list
// and drops any pending result; slot contents are not cleared.
module stable_priority_queue #(
  parameter int DEPTH         = 16,
  parameter int PRIORITY_BITS = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [2:0]                          kind,
  input  logic signed [spq_pkg::VALUE_W-1:0]  item_value,
  input  logic [PRIORITY_BITS-1:0]            item_priority,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [1:0]                          status,
  output logic signed [spq_pkg::VALUE_W-1:0]  out_value,
  output logic [PRIORITY_BITS-1:0]            out_priority,
  output logic [$clog2(DEPTH)-1:0]            position,
  output logic [$clog2(DEPTH+1)-1:0]          occupancy
);
  import spq_pkg::*;

  localparam int POS_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  logic  accept;
  kind_t op;
  cmd_t  cmd;
  logic  full;
  logic  empty;
  logic  found;

  // Per-slot wiring of the chain.
  logic                          cell_valid [DEPTH];
  logic                          valid_rgt  [DEPTH];
  logic                          ge_lft     [DEPTH];
  logic                          match_lft  [DEPTH];
  logic signed [VALUE_W-1:0]     val_lft    [DEPTH];
  logic        [PRIORITY_BITS-1:0] pri_lft  [DEPTH];
  logic signed [VALUE_W-1:0]     val_rgt    [DEPTH];
  logic        [PRIORITY_BITS-1:0] pri_rgt  [DEPTH];
  cell_flags_t                   flags      [DEPTH];
  logic signed [VALUE_W-1:0]     cell_val   [DEPTH];
  logic        [PRIORITY_BITS-1:0] cell_pri [DEPTH];

  // Collected from the row.
  logic signed [VALUE_W-1:0]       hit_val;
  logic        [PRIORITY_BITS-1:0] hit_pri;
  logic        [POS_W-1:0]         hit_pos;
  logic        [POS_W-1:0]         ins_pos;

  // Next result word.
  status_t                         res_status;
  logic signed [VALUE_W-1:0]       res_val;
  logic        [PRIORITY_BITS-1:0] res_pri;
  logic        [POS_W-1:0]         res_pos;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;
  assign op       = kind_t'(kind);
  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign found    = flags[DEPTH-1].match_incl;

  // Only ops that change the list shift the cells.
  always_comb begin
    cmd.kind = op;
    unique case (op)
      KIND_INSERT:       cmd.apply = accept && !full;
      KIND_POP_FRONT,
      KIND_REMOVE_BACK:  cmd.apply = accept && !empty;
      KIND_REMOVE_VALUE: cmd.apply = accept && found;
      default:           cmd.apply = 1'b0;
    endcase
  end

  // Slot i holds a live entry when i < count.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      cell_valid[i] = (CNT_W'(i) < count);
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    if (g == 0) begin : g_front
      assign ge_lft[g]    = 1'b1;
      assign match_lft[g] = 1'b0;
      assign val_lft[g]   = '0;
      assign pri_lft[g]   = '0;
    end else begin : g_mid_l
      assign ge_lft[g]    = flags[g-1].ge;
      assign match_lft[g] = flags[g-1].match_incl;
      assign val_lft[g]   = cell_val[g-1];
      assign pri_lft[g]   = cell_pri[g-1];
    end
    if (g == DEPTH - 1) begin : g_back
      assign valid_rgt[g] = 1'b0;
      assign val_rgt[g]   = '0;
      assign pri_rgt[g]   = '0;
    end else begin : g_mid_r
      assign valid_rgt[g] = cell_valid[g+1];
      assign val_rgt[g]   = cell_val[g+1];
      assign pri_rgt[g]   = cell_pri[g+1];
    end

    spq_cell #(
      .PRIORITY_BITS(PRIORITY_BITS)
    ) u_cell (
      .clk          (clk),
      .cmd          (cmd),
      .new_value    (item_value),
      .new_prio     (item_priority),
      .valid_here   (cell_valid[g]),
      .valid_right  (valid_rgt[g]),
      .left_ge      (ge_lft[g]),
      .match_before (match_lft[g]),
      .left_value   (val_lft[g]),
      .left_prio    (pri_lft[g]),
      .right_value  (val_rgt[g]),
      .right_prio   (pri_rgt[g]),
      .flags        (flags[g]),
      .entry_value  (cell_val[g]),
      .entry_prio   (cell_pri[g])
    );
  end

  // Hit and insert flags are one-hot, so an OR gathers them.
  always_comb begin
    hit_val = '0;
    hit_pri = '0;
    hit_pos = '0;
    ins_pos = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (flags[i].hit) begin
        hit_val = hit_val | cell_val[i];
        hit_pri = hit_pri | cell_pri[i];
        hit_pos = hit_pos | POS_W'(i);
      end
      if (flags[i].ins) begin
        ins_pos = ins_pos | POS_W'(i);
      end
    end
  end

  always_comb begin
    res_status = ST_DONE;
    res_val    = '0;
    res_pri    = '0;
    res_pos    = '0;
    count_next = count;
    unique case (op)
      KIND_INSERT: begin
        if (full) begin
          res_status = ST_FULL;
        end else begin
          res_val    = item_value;
          res_pri    = item_priority;
          res_pos    = ins_pos;
          count_next = count + CNT_W'(1);
        end
      end
      KIND_POP_FRONT: begin
        if (empty) begin
          res_status = ST_EMPTY;
        end else begin
          res_val    = cell_val[0];
          res_pri    = cell_pri[0];
          count_next = count - CNT_W'(1);
        end
      end
      KIND_REMOVE_BACK: begin
        if (empty) begin
          res_status = ST_EMPTY;
        end else begin
          res_val    = hit_val;
          res_pri    = hit_pri;
          res_pos    = hit_pos;
          count_next = count - CNT_W'(1);
        end
      end
      KIND_REMOVE_VALUE, KIND_SEARCH: begin
        if (empty) begin
          res_status = ST_EMPTY;
        end else if (!found) begin
          res_status = ST_NOTFOUND;
        end else begin
          res_val = hit_val;
          res_pri = hit_pri;
          res_pos = hit_pos;
          if (op == KIND_REMOVE_VALUE) begin
            count_next = count - CNT_W'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        count <= count_next;
      end
      priority if (accept) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result word.
  always_ff @(posedge clk) begin
    if (accept) begin
      status       <= res_status;
      out_value    <= res_val;
      out_priority <= res_pri;
      position     <= res_pos;
      occupancy    <= count_next;
    end
  end

endmodule

// ===== rtl/spq_checker.sv =====
// Port-level checks for stable_priority_queue, attached by bind.
// Depends on spq_pkg and stable_priority_queue_macros.svh.
`include "stable_priority_queue_macros.svh"

module spq_checker #(
  parameter int DEPTH         = 16,
  parameter int PRIORITY_BITS = 8
) (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic [2:0]                          kind,
  input logic signed [spq_pkg::VALUE_W-1:0]  item_value,
  input logic [PRIORITY_BITS-1:0]            item_priority,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic [1:0]                          status,
  input logic signed [spq_pkg::VALUE_W-1:0]  out_value,
  input logic [PRIORITY_BITS-1:0]            out_priority,
  input logic [$clog2(DEPTH)-1:0]            position,
  input logic [$clog2(DEPTH+1)-1:0]          occupancy
);
  import spq_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);

  `SPQ_CHECK_RST(a_reset_clears, rst |=> !out_valid, "result pending after reset")

  `SPQ_CHECK(a_result_follows, (in_valid && !in_stall) |=> out_valid, "accepted word gave no result")

  `SPQ_CHECK(a_held_result, (out_valid && out_stall) |=> (out_valid && $stable(out_value) && $stable(status)), "stalled result changed")

  `SPQ_CHECK(a_full_count, (out_valid && status == ST_FULL) |-> (occupancy == CNT_W'(DEPTH)), "full status below capacity")

  `SPQ_CHECK(a_empty_count, (out_valid && status == ST_EMPTY) |-> (occupancy == '0), "empty status with entries held")

endmodule

bind stable_priority_queue spq_checker #(
  .DEPTH         (DEPTH),
  .PRIORITY_BITS (PRIORITY_BITS)
) u_spq_checker (.*);
